// ----- rtl/byte_fifo_can_frame_packer_core_macros.svh -----
// assertion helpers used by the packer core rtl
`ifndef BYTE_FIFO_CAN_FRAME_PACKER_CORE_MACROS_SVH
`define BYTE_FIFO_CAN_FRAME_PACKER_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define BFCFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define BFCFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/bfcfp_pkg.sv -----
`timescale 1ns / 1ps

package bfcfp_pkg;

   localparam int DEPTH       = 128;
   localparam int FRAME_BYTES = 8;
   localparam int MAX_FRAME   = 8;
   localparam int NMAX        = (FRAME_BYTES < MAX_FRAME) ? FRAME_BYTES : MAX_FRAME;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = PTR_W;            // fill never passes DEPTH-1
   localparam int FLEN_W = 4;
   localparam int IDX_W  = 3;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] END_MARK = 8'hFF;

   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_POP    = 1'b1;

   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [FLEN_W-1:0] flen_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

   // circular index add, both operands below DEPTH
   function automatic ptr_type ptr_add(input ptr_type a, input ptr_type b);
      logic [PTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PTR_W+1)'(DEPTH)) begin
         s = s - (PTR_W+1)'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

// ----- rtl/bfcfp_store.sv -----
`timescale 1ns / 1ps

module bfcfp_store (
   input  logic               clock,
   input  logic               wr_en,
   input  bfcfp_pkg::ptr_type  wr_addr,
   input  bfcfp_pkg::byte_type wr_data,
   input  bfcfp_pkg::ptr_type  rd_addr,
   output bfcfp_pkg::byte_type rd_data
);
   import bfcfp_pkg::*;

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read every cycle; the registered word doubles as the output byte
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/byte_fifo_can_frame_packer_core.sv -----
`timescale 1ns / 1ps

// Byte queue for debug characters, drained as CAN payloads. An append word
// (req_tuser low) stores req_tdata unless the queue already holds DEPTH-1
// bytes (status full) or the byte is 0xFF (accepted with ok, not stored),
// and returns one word with rsp_tlast set. A pop word (req_tuser high)
// returns the oldest min(fill, 8) bytes, one word each, with byte index and
// frame length, rsp_tlast on the final byte; an empty pop returns one word
// of zeros with rsp_tlast. After an append or an empty pop, the next word
// is taken no earlier than the cycle in which its result is taken. A pop
// of n bytes goes through the accepting cycle, a registered read from the
// single read port of the queue memory, then one byte per cycle while the
// sink is ready, a stall holding the shown byte; the last byte retires the
// frame, and no word is taken before that. No reset sweep of the memory.
module byte_fifo_can_frame_packer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] frame_byte, [10:8] byte_index,
                                    // [14:11] frame_length, [15] zero
   output logic [1:0]  rsp_tuser,   // [0] status, [1] byte_valid
   output logic        rsp_tlast
);
   import bfcfp_pkg::*;
   `include "byte_fifo_can_frame_packer_core_macros.svh"

   state_type state_ff, state_in;
   ptr_type   head_ff, head_in;
   cnt_type   fill_ff, fill_in;
   flen_type  n_ff, n_in;
   flen_type  show_k_ff, show_k_in;
   flen_type  next_k_ff, next_k_in;
   logic      show_ff, show_in;
   logic      one_valid_ff, one_valid_in;
   logic      one_status_ff, one_status_in;

   logic      req_accept;
   logic      advance;
   logic      pop_mode;
   logic      full;
   flen_type  n_calc;
   flen_type  sel_k;
   logic      wr_en;
   ptr_type   wr_addr;
   ptr_type   rd_addr;
   byte_type  rd_data;

   assign pop_mode   = (state_ff == ST_POP);
   assign req_tready = (state_ff == ST_IDLE) && (!one_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign full       = (fill_ff >= CNT_W'(DEPTH - 1));
   assign n_calc     = (fill_ff >= CNT_W'(NMAX)) ? FLEN_W'(NMAX) : FLEN_W'(fill_ff);
   assign advance    = !show_ff || rsp_tready;

   // on a stall the shown byte is read again, so the memory word holds
   assign sel_k   = advance ? next_k_ff : show_k_ff;
   assign rd_addr = ptr_add(head_ff, PTR_W'(sel_k));
   assign wr_addr = ptr_add(head_ff, fill_ff);

   bfcfp_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      n_in          = n_ff;
      show_in       = show_ff;
      show_k_in     = show_k_ff;
      next_k_in     = next_k_ff;
      one_valid_in  = one_valid_ff;
      one_status_in = one_status_ff;
      wr_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (one_valid_ff && rsp_tready) begin
               one_valid_in = 1'b0;
            end
            if (req_accept) begin
               if (req_tuser == FUNC_APPEND) begin
                  one_valid_in = 1'b1;
                  if (full) begin
                     one_status_in = STAT_FULL;
                  end else begin
                     one_status_in = STAT_OK;
                     if (req_tdata != END_MARK) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
               end else if (n_calc == '0) begin
                  one_valid_in  = 1'b1;
                  one_status_in = STAT_OK;
               end else begin
                  state_in  = ST_POP;
                  n_in      = n_calc;
                  next_k_in = '0;
                  show_in   = 1'b0;
               end
            end
         end
         ST_POP: begin
            if (advance) begin
               if (next_k_ff != n_ff) begin
                  show_in   = 1'b1;
                  show_k_in = next_k_ff;
                  next_k_in = next_k_ff + FLEN_W'(1);
               end else begin
                  // final byte taken: retire the frame
                  show_in  = 1'b0;
                  state_in = ST_IDLE;
                  head_in  = ptr_add(head_ff, PTR_W'(n_ff));
                  fill_in  = fill_ff - CNT_W'(n_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         show_ff      <= 1'b0;
         one_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         show_ff      <= show_in;
         one_valid_ff <= one_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      show_k_ff     <= show_k_in;
      next_k_ff     <= next_k_in;
      one_status_ff <= one_status_in;
   end

   assign rsp_tvalid = pop_mode ? show_ff : one_valid_ff;
   assign rsp_tdata  = pop_mode ? {1'b0, n_ff, show_k_ff[IDX_W-1:0], rd_data} : '0;
   assign rsp_tuser  = pop_mode ? {1'b1, STAT_OK} : {1'b0, one_status_ff};
   assign rsp_tlast  = pop_mode ? ((show_k_ff + FLEN_W'(1)) == n_ff) : 1'b1;

   `BFCFP_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE) && !rsp_tvalid, "not idle after reset")
   `BFCFP_ASSERT(a_fill_bound, fill_ff <= CNT_W'(DEPTH - 1), "fill count past capacity")
   `BFCFP_ASSERT(a_pop_frame_sane, pop_mode |-> (n_ff != '0) && (next_k_ff <= n_ff), "bad frame count")
   `BFCFP_ASSERT(a_stall_holds_byte, (pop_mode && rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata), "stalled byte changed")
   `BFCFP_ASSERT(a_retire_fill, ($past(state_ff == ST_POP) && (state_ff == ST_IDLE)) |-> (fill_ff == $past(fill_ff) - CNT_W'($past(n_ff))), "fill not reduced by frame")

endmodule
